[rtl/sprite_quad_scissor_clipper_core_assert.svh]
// Assertion macros used by the sprite quad scissor clipper checker.
`ifndef SPRITE_QUAD_SCISSOR_CLIPPER_CORE_ASSERT_SVH
`define SPRITE_QUAD_SCISSOR_CLIPPER_CORE_ASSERT_SVH
// Assertion that is switched off while reset is high.
`define SQSC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sqsc assertion failed");
// Assertion that is checked at every edge, reset included.
`define SQSC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("sqsc assertion failed");
`endif

[rtl/sqsc_pkg.sv]
// Types, constants and tables of the sprite quad scissor clipper.
package sqsc_pkg;

  localparam int POS_W   = 24;
  localparam int SIZE_W  = 22;
  localparam int UV_W    = 25;
  localparam int TEX_W   = 15;
  localparam int ANC_W   = 4;
  localparam int FLIP_W  = 2;
  localparam int ROT_W   = 16;
  localparam int EDGE_W  = 26;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam int TRIM_QW = 22;
  localparam int TRIM_DW = 44;
  localparam int UV_QW   = 24;
  localparam int UV_DW   = 31;
  localparam int UVT_W   = 23;

  localparam logic [ANC_W-1:0] ANCHOR_CODE_TL = 4'd1;
  localparam logic [EDGE_W-1:0] POS_MAX_E = 26'h07FFFFF;
  localparam logic [POS_W-1:0] POS_MAX = 24'h7FFFFF;

  typedef enum logic [2:0] {
    REG_CLIP_LEFT,
    REG_CLIP_TOP,
    REG_CLIP_WIDTH,
    REG_CLIP_HEIGHT,
    REG_TEX_WIDTH,
    REG_TEX_HEIGHT
  } reg_idx_t;

  // Anchor factors in halves of the quad size; unknown codes act as center.
  localparam logic [1:0] ANCHOR_KX [16] = '{2'd1, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd0,
                                            2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1};
  localparam logic [1:0] ANCHOR_KY [16] = '{2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2,
                                            2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1};

  typedef struct packed {
    logic [POS_W-1:0]  clip_left;
    logic [POS_W-1:0]  clip_top;
    logic [SIZE_W-1:0] clip_width;
    logic [SIZE_W-1:0] clip_height;
  } clip_cfg_t;

  typedef struct packed {
    logic [TEX_W-1:0] texture_width;
    logic [TEX_W-1:0] texture_height;
  } tex_cfg_t;

  // Word passed from the front end to the back end through the queue.
  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SIZE_W-1:0] wid;
    logic [SIZE_W-1:0] hgt;
    logic [SIZE_W-1:0] tx;
    logic [SIZE_W-1:0] ty;
    logic [SIZE_W-1:0] tw;
    logic [SIZE_W-1:0] th;
    logic [SIZE_W-1:0] t1x;
    logic [SIZE_W-1:0] t2x;
    logic [SIZE_W-1:0] t1y;
    logic [SIZE_W-1:0] t2y;
    logic [SIZE_W-1:0] qw;
    logic [SIZE_W-1:0] qh;
    logic [ANC_W-1:0]  anchor;
    logic [FLIP_W-1:0] flip;
    logic [ROT_W-1:0]  rot;
    logic              clipped;
  } fq_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SIZE_W-1:0] wid;
    logic [SIZE_W-1:0] hgt;
    logic [SIZE_W-1:0] tx;
    logic [SIZE_W-1:0] ty;
    logic [SIZE_W-1:0] tw;
    logic [SIZE_W-1:0] th;
    logic [ANC_W-1:0]  anchor;
    logic [FLIP_W-1:0] flip;
    logic [ROT_W-1:0]  rot;
    logic              clipped;
    logic              zx;
    logic              zy;
  } pass_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SIZE_W-1:0] wid;
    logic [SIZE_W-1:0] hgt;
    logic [UVT_W-1:0]  txn;
    logic [UVT_W-1:0]  tyn;
    logic [SIZE_W-1:0] twn;
    logic [SIZE_W-1:0] thn;
    logic [ANC_W-1:0]  anchor;
    logic [FLIP_W-1:0] flip;
    logic [ROT_W-1:0]  rot;
    logic              clipped;
  } comb_t;

endpackage

[rtl/sqsc_quad_if.sv]
// Input channel carrying one sprite quad per word.
interface sqsc_quad_if import sqsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [SIZE_W-1:0] quad_width;
  logic [SIZE_W-1:0] quad_height;
  logic [SIZE_W-1:0] texel_x;
  logic [SIZE_W-1:0] texel_y;
  logic [SIZE_W-1:0] texel_w;
  logic [SIZE_W-1:0] texel_h;
  logic [ANC_W-1:0]  anchor;
  logic [FLIP_W-1:0] flip_bits;
  logic [ROT_W-1:0]  rotation;
  logic              bypass_clip;

  modport source (output valid, pos_x, pos_y, quad_width, quad_height, texel_x, texel_y,
                  texel_w, texel_h, anchor, flip_bits, rotation, bypass_clip, input ready);
  modport sink (input valid, pos_x, pos_y, quad_width, quad_height, texel_x, texel_y,
                texel_w, texel_h, anchor, flip_bits, rotation, bypass_clip, output ready);
endinterface

[rtl/sqsc_res_if.sv]
// Output channel carrying one clipped quad per word.
interface sqsc_res_if import sqsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  out_pos_x;
  logic [POS_W-1:0]  out_pos_y;
  logic [SIZE_W-1:0] out_width;
  logic [SIZE_W-1:0] out_height;
  logic [UV_W-1:0]   uv_u;
  logic [UV_W-1:0]   uv_v;
  logic [UV_W-1:0]   uv_width;
  logic [UV_W-1:0]   uv_height;
  logic [ANC_W-1:0]  out_anchor;
  logic [FLIP_W-1:0] out_flip_bits;
  logic [ROT_W-1:0]  out_rotation;
  logic              was_clipped;

  modport source (output valid, out_pos_x, out_pos_y, out_width, out_height, uv_u, uv_v,
                  uv_width, uv_height, out_anchor, out_flip_bits, out_rotation, was_clipped,
                  input ready);
  modport sink (input valid, out_pos_x, out_pos_y, out_width, out_height, uv_u, uv_v,
                uv_width, uv_height, out_anchor, out_flip_bits, out_rotation, was_clipped,
                output ready);
endinterface

[rtl/sqsc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, saturating.
module sqsc_div #(
  parameter int DW = 44,
  parameter int VW = 22,
  parameter int QW = 22
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [QW-1:0] quotient
);

  localparam int CW = VW + QW + 1;

  logic [CW-1:0] rem [QW];
  logic [VW-1:0] dv  [QW];
  logic [QW-1:0] qt  [QW+1];
  logic          ovf [QW+1];

  // A quotient that needs more than QW bits saturates to all ones.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= CW'(dividend);
      dv[0]  <= divisor;
      qt[0]  <= '0;
      ovf[0] <= CW'(dividend) >= (CW'(divisor) << QW);
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [CW-1:0] cand;
    logic          ge;
    logic [QW-1:0] qt_next;

    always_comb begin
      cand       = CW'(dv[s]) << B;
      ge         = rem[s] >= cand;
      qt_next    = qt[s];
      qt_next[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qt[s+1]  <= qt_next;
        ovf[s+1] <= ovf[s];
      end
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= ge ? rem[s] - cand : rem[s];
          dv[s+1]  <= dv[s];
        end
      end
    end
  end

  assign quotient = ovf[QW] ? '1 : qt[QW];

endmodule

[rtl/sqsc_queue.sv]
// Small FIFO between the front end and the back end.
module sqsc_queue import sqsc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  fq_t  wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output fq_t  rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fq_t           mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = count != (AW + 1)'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

[rtl/sqsc_front.sv]
// Front end: places the quad by its anchor, culls it and computes the trims.
module sqsc_front import sqsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  sqsc_quad_if.sink   quad_in,
  input  clip_cfg_t   cfg,
  output logic        push_valid,
  input  logic        push_ready,
  output fq_t         push_data
);

  // Placement stage registers.
  logic              a_v;
  logic              a_clip;
  logic [EDGE_W-1:0] a_l, a_r, a_t, a_b;
  logic [POS_W-1:0]  a_px, a_py;
  logic [SIZE_W-1:0] a_qw, a_qh, a_tx, a_ty, a_tw, a_th;
  logic [ANC_W-1:0]  a_anchor;
  logic [FLIP_W-1:0] a_flip;
  logic [ROT_W-1:0]  a_rot;

  // Trim stage registers.
  logic b_v;
  logic b_cull;
  fq_t  b_data;

  logic              a_free, b_free;
  logic [SIZE_W-1:0] off_x, off_y;
  logic [EDGE_W-1:0] l_c, r_c, t_c, b_c;
  logic [EDGE_W-1:0] cl, ct, cr, cb, x1, x2, y1, y2;
  logic              cull_c;
  fq_t               b_next;

  assign push_valid    = b_v && !b_cull;
  assign push_data     = b_data;
  assign b_free        = !b_v || b_cull || push_ready;
  assign a_free        = !a_v || b_free;
  assign quad_in.ready = a_free;

  always_comb begin
    unique case (ANCHOR_KX[quad_in.anchor])
      2'd0:    off_x = '0;
      2'd1:    off_x = quad_in.quad_width >> 1;
      default: off_x = quad_in.quad_width;
    endcase
    unique case (ANCHOR_KY[quad_in.anchor])
      2'd0:    off_y = '0;
      2'd1:    off_y = quad_in.quad_height >> 1;
      default: off_y = quad_in.quad_height;
    endcase
    l_c = {{2{quad_in.pos_x[POS_W-1]}}, quad_in.pos_x} - {4'b0, off_x};
    t_c = {{2{quad_in.pos_y[POS_W-1]}}, quad_in.pos_y} - {4'b0, off_y};
    r_c = l_c + {4'b0, quad_in.quad_width};
    b_c = t_c + {4'b0, quad_in.quad_height};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_free) begin
      a_v <= quad_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && quad_in.valid) begin
      a_clip   <= !quad_in.bypass_clip && (cfg.clip_width != '0) && (cfg.clip_height != '0);
      a_l      <= l_c;
      a_r      <= r_c;
      a_t      <= t_c;
      a_b      <= b_c;
      a_px     <= quad_in.pos_x;
      a_py     <= quad_in.pos_y;
      a_qw     <= quad_in.quad_width;
      a_qh     <= quad_in.quad_height;
      a_tx     <= quad_in.texel_x;
      a_ty     <= quad_in.texel_y;
      a_tw     <= quad_in.texel_w;
      a_th     <= quad_in.texel_h;
      a_anchor <= quad_in.anchor;
      a_flip   <= quad_in.flip_bits;
      a_rot    <= quad_in.rotation;
    end
  end

  always_comb begin
    cl = {{2{cfg.clip_left[POS_W-1]}}, cfg.clip_left};
    ct = {{2{cfg.clip_top[POS_W-1]}}, cfg.clip_top};
    cr = cl + {4'b0, cfg.clip_width};
    cb = ct + {4'b0, cfg.clip_height};
    // Edges that only touch the scissor edge keep the quad.
    cull_c = a_clip && (($signed(a_l) > $signed(cr)) || ($signed(a_r) < $signed(cl)) ||
                        ($signed(a_t) > $signed(cb)) || ($signed(a_b) < $signed(ct)));
    x1 = ($signed(a_l) > $signed(cl)) ? a_l : cl;
    y1 = ($signed(a_t) > $signed(ct)) ? a_t : ct;
    x2 = ($signed(a_r) < $signed(cr)) ? a_r : cr;
    y2 = ($signed(a_b) < $signed(cb)) ? a_b : cb;

    b_next.tx   = a_tx;
    b_next.ty   = a_ty;
    b_next.tw   = a_tw;
    b_next.th   = a_th;
    b_next.qw   = a_qw;
    b_next.qh   = a_qh;
    b_next.flip = a_flip;
    if (a_clip) begin
      b_next.pos_x   = ($signed(x1) > $signed(POS_MAX_E)) ? POS_MAX : x1[POS_W-1:0];
      b_next.pos_y   = ($signed(y1) > $signed(POS_MAX_E)) ? POS_MAX : y1[POS_W-1:0];
      b_next.wid     = SIZE_W'(x2 - x1);
      b_next.hgt     = SIZE_W'(y2 - y1);
      b_next.t1x     = SIZE_W'(x1 - a_l);
      b_next.t2x     = SIZE_W'(a_r - x2);
      b_next.t1y     = SIZE_W'(y1 - a_t);
      b_next.t2y     = SIZE_W'(a_b - y2);
      b_next.anchor  = ANCHOR_CODE_TL;
      b_next.rot     = '0;
      b_next.clipped = 1'b1;
    end else begin
      b_next.pos_x   = a_px;
      b_next.pos_y   = a_py;
      b_next.wid     = a_qw;
      b_next.hgt     = a_qh;
      b_next.t1x     = '0;
      b_next.t2x     = '0;
      b_next.t1y     = '0;
      b_next.t2y     = '0;
      b_next.anchor  = a_anchor;
      b_next.rot     = a_rot;
      b_next.clipped = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (b_free) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && a_v) begin
      b_cull <= cull_c;
      b_data <= b_next;
    end
  end

endmodule

[rtl/sqsc_back.sv]
// Back end: texel trim division, texel adjust and UV normalization.
module sqsc_back import sqsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_valid,
  output logic        rd_ready,
  input  fq_t         rd_data,
  input  tex_cfg_t    tex,
  sqsc_res_if.source  res_out
);

  localparam int LT = TRIM_QW + 1;
  localparam int LU = UV_QW + 1;
  localparam int NS = 1 + LT + 1 + LU;

  logic              en;
  logic              vs [NS];
  logic              out_v;
  pass_t             p1 [LT+1];
  comb_t             p2 [LU+1];
  logic [TRIM_DW-1:0] m1x, m2x, m1y, m2y;
  logic [SIZE_W-1:0] dqw, dqh;
  logic [TRIM_QW-1:0] q1x, q2x, q1y, q2y;
  logic [SIZE_W-1:0] d1x, d2x, d1y, d2y;
  logic [TEX_W-1:0]  tw_eff, th_eff;
  logic [UV_QW-1:0]  qu, qv, qw_uv, qh_uv;
  comb_t             c_next;
  comb_t             c_last;

  // The whole pipeline moves together unless the result word is stalled.
  assign en       = !out_v || res_out.ready;
  assign rd_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        vs[i] <= 1'b0;
      end
      out_v <= 1'b0;
    end else if (en) begin
      vs[0] <= rd_valid;
      for (int i = 1; i < NS; i++) begin
        vs[i] <= vs[i-1];
      end
      out_v <= vs[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1x <= rd_data.t1x * rd_data.tw;
      m2x <= rd_data.t2x * rd_data.tw;
      m1y <= rd_data.t1y * rd_data.th;
      m2y <= rd_data.t2y * rd_data.th;
      dqw <= rd_data.qw;
      dqh <= rd_data.qh;
      p1[0].pos_x   <= rd_data.pos_x;
      p1[0].pos_y   <= rd_data.pos_y;
      p1[0].wid     <= rd_data.wid;
      p1[0].hgt     <= rd_data.hgt;
      p1[0].tx      <= rd_data.tx;
      p1[0].ty      <= rd_data.ty;
      p1[0].tw      <= rd_data.tw;
      p1[0].th      <= rd_data.th;
      p1[0].anchor  <= rd_data.anchor;
      p1[0].flip    <= rd_data.flip;
      p1[0].rot     <= rd_data.rot;
      p1[0].clipped <= rd_data.clipped;
      p1[0].zx      <= rd_data.qw == '0;
      p1[0].zy      <= rd_data.qh == '0;
      for (int i = 1; i <= LT; i++) begin
        p1[i] <= p1[i-1];
      end
    end
  end

  sqsc_div #(.DW(TRIM_DW), .VW(SIZE_W), .QW(TRIM_QW)) u_div_1x (
    .clk(clk), .en(en), .dividend(m1x), .divisor(dqw), .quotient(q1x));
  sqsc_div #(.DW(TRIM_DW), .VW(SIZE_W), .QW(TRIM_QW)) u_div_2x (
    .clk(clk), .en(en), .dividend(m2x), .divisor(dqw), .quotient(q2x));
  sqsc_div #(.DW(TRIM_DW), .VW(SIZE_W), .QW(TRIM_QW)) u_div_1y (
    .clk(clk), .en(en), .dividend(m1y), .divisor(dqh), .quotient(q1y));
  sqsc_div #(.DW(TRIM_DW), .VW(SIZE_W), .QW(TRIM_QW)) u_div_2y (
    .clk(clk), .en(en), .dividend(m2y), .divisor(dqh), .quotient(q2y));

  // A zero quad size gives no texel trim.
  always_comb begin
    d1x = p1[LT].zx ? '0 : q1x;
    d2x = p1[LT].zx ? '0 : q2x;
    d1y = p1[LT].zy ? '0 : q1y;
    d2y = p1[LT].zy ? '0 : q2y;
    c_next.pos_x   = p1[LT].pos_x;
    c_next.pos_y   = p1[LT].pos_y;
    c_next.wid     = p1[LT].wid;
    c_next.hgt     = p1[LT].hgt;
    c_next.txn     = UVT_W'(p1[LT].tx) + UVT_W'(d1x);
    c_next.tyn     = UVT_W'(p1[LT].ty) + UVT_W'(d1y);
    c_next.twn     = p1[LT].tw - d1x - d2x;
    c_next.thn     = p1[LT].th - d1y - d2y;
    c_next.anchor  = p1[LT].anchor;
    c_next.flip    = p1[LT].flip;
    c_next.rot     = p1[LT].rot;
    c_next.clipped = p1[LT].clipped;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2[0] <= c_next;
      for (int i = 1; i <= LU; i++) begin
        p2[i] <= p2[i-1];
      end
    end
  end

  assign tw_eff = (tex.texture_width == '0) ? TEX_W'(1) : tex.texture_width;
  assign th_eff = (tex.texture_height == '0) ? TEX_W'(1) : tex.texture_height;

  sqsc_div #(.DW(UV_DW), .VW(TEX_W), .QW(UV_QW)) u_div_u (
    .clk(clk), .en(en), .dividend({p2[0].txn, 8'b0}), .divisor(tw_eff), .quotient(qu));
  sqsc_div #(.DW(UV_DW), .VW(TEX_W), .QW(UV_QW)) u_div_v (
    .clk(clk), .en(en), .dividend({p2[0].tyn, 8'b0}), .divisor(th_eff), .quotient(qv));
  sqsc_div #(.DW(UV_DW), .VW(TEX_W), .QW(UV_QW)) u_div_w (
    .clk(clk), .en(en), .dividend({1'b0, p2[0].twn, 8'b0}), .divisor(tw_eff),
    .quotient(qw_uv));
  sqsc_div #(.DW(UV_DW), .VW(TEX_W), .QW(UV_QW)) u_div_h (
    .clk(clk), .en(en), .dividend({1'b0, p2[0].thn, 8'b0}), .divisor(th_eff),
    .quotient(qh_uv));

  assign c_last = p2[LU];

  always_ff @(posedge clk) begin
    if (en) begin
      res_out.out_pos_x     <= c_last.pos_x;
      res_out.out_pos_y     <= c_last.pos_y;
      res_out.out_width     <= c_last.wid;
      res_out.out_height    <= c_last.hgt;
      res_out.uv_u          <= {1'b0, qu};
      res_out.uv_v          <= {1'b0, qv};
      res_out.uv_width      <= {1'b0, qw_uv};
      res_out.uv_height     <= {1'b0, qh_uv};
      res_out.out_anchor    <= c_last.anchor;
      res_out.out_flip_bits <= c_last.flip;
      res_out.out_rotation  <= c_last.rot;
      res_out.was_clipped   <= c_last.clipped;
    end
  end

  assign res_out.valid = out_v;

endmodule

[rtl/sprite_quad_scissor_clipper_core.sv]
// Top level of the sprite quad scissor clipper: registers, front end, queue, back end.
//
//  channel   dir  handshake            word
//  quad_in   in   valid / ready        one sprite quad
//  res_out   out  valid / ready        one clipped, normalized quad
//  apb       in   psel/penable/pready  register write and read
//
// One quad is taken every cycle while the result side keeps up.
// The path from the accepting edge to a valid result word is mostly set by the
// two chained dividers of the back end (22 trim quotient bits, then 24 UV quotient bits,
// one bit per stage).
// Culled quads leave no word. Reset clears all valid flags and the queue.
// A stalled result word freezes the back end; the queue and front end keep
// taking quads until the queue is full.
module sprite_quad_scissor_clipper_core import sqsc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  sqsc_quad_if.sink         quad_in,
  sqsc_res_if.source        res_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  clip_cfg_t clip_cfg;
  tex_cfg_t  tex_cfg;
  reg_idx_t  reg_sel;
  logic      push_valid, push_ready, pop_valid, pop_ready;
  fq_t       push_data, pop_data;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_cfg               <= '0;
      tex_cfg.texture_width  <= TEX_W'(1);
      tex_cfg.texture_height <= TEX_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_CLIP_LEFT:   clip_cfg.clip_left      <= pwdata[POS_W-1:0];
        REG_CLIP_TOP:    clip_cfg.clip_top       <= pwdata[POS_W-1:0];
        REG_CLIP_WIDTH:  clip_cfg.clip_width     <= pwdata[SIZE_W-1:0];
        REG_CLIP_HEIGHT: clip_cfg.clip_height    <= pwdata[SIZE_W-1:0];
        REG_TEX_WIDTH:   tex_cfg.texture_width   <= pwdata[TEX_W-1:0];
        REG_TEX_HEIGHT:  tex_cfg.texture_height  <= pwdata[TEX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CLIP_LEFT:   prdata = DATA_W'(clip_cfg.clip_left);
      REG_CLIP_TOP:    prdata = DATA_W'(clip_cfg.clip_top);
      REG_CLIP_WIDTH:  prdata = DATA_W'(clip_cfg.clip_width);
      REG_CLIP_HEIGHT: prdata = DATA_W'(clip_cfg.clip_height);
      REG_TEX_WIDTH:   prdata = DATA_W'(tex_cfg.texture_width);
      REG_TEX_HEIGHT:  prdata = DATA_W'(tex_cfg.texture_height);
      default:         prdata = '0;
    endcase
  end

  sqsc_front u_front (
    .clk(clk), .rst(rst), .quad_in(quad_in), .cfg(clip_cfg),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data));

  sqsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(push_valid), .wr_ready(push_ready), .wr_data(push_data),
    .rd_valid(pop_valid), .rd_ready(pop_ready), .rd_data(pop_data));

  sqsc_back u_back (
    .clk(clk), .rst(rst), .rd_valid(pop_valid), .rd_ready(pop_ready), .rd_data(pop_data),
    .tex(tex_cfg), .res_out(res_out));

endmodule

[rtl/sqsc_checker.sv]
// Port-level checks of the sprite quad scissor clipper and their binding.
`include "sprite_quad_scissor_clipper_core_assert.svh"
module sqsc_checker import sqsc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [POS_W-1:0]  out_pos_x,
  input logic [SIZE_W-1:0] out_width,
  input logic [ANC_W-1:0]  out_anchor,
  input logic [ROT_W-1:0]  out_rotation,
  input logic              was_clipped
);

  `SQSC_ASSERT_ALWAYS(a_reset_empty, clk, (rst |=> !out_valid && in_ready))
  `SQSC_ASSERT(a_valid_held, clk, rst, (out_valid && !out_ready |=> out_valid))
  `SQSC_ASSERT(a_word_held, clk, rst, (out_valid && !out_ready |=> $stable({out_pos_x, out_width, out_anchor, was_clipped})))
  `SQSC_ASSERT(a_clip_form, clk, rst, (out_valid && was_clipped |-> out_anchor == ANCHOR_CODE_TL && out_rotation == '0))

endmodule

bind sprite_quad_scissor_clipper_core sqsc_checker u_sqsc_checker (
  .clk(clk), .rst(rst), .in_ready(quad_in.ready),
  .out_valid(res_out.valid), .out_ready(res_out.ready),
  .out_pos_x(res_out.out_pos_x), .out_width(res_out.out_width),
  .out_anchor(res_out.out_anchor), .out_rotation(res_out.out_rotation),
  .was_clipped(res_out.was_clipped));

[tb/sv/tb_sprite_quad_scissor_clipper_core.sv]
// Self-checking testbench for the sprite quad scissor clipper core.
`timescale 1ns / 100ps

module tb_sprite_quad_scissor_clipper_core;
  import sqsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 90;

  typedef struct {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SIZE_W-1:0] quad_width;
    logic [SIZE_W-1:0] quad_height;
    logic [SIZE_W-1:0] texel_x;
    logic [SIZE_W-1:0] texel_y;
    logic [SIZE_W-1:0] texel_w;
    logic [SIZE_W-1:0] texel_h;
    logic [ANC_W-1:0]  anchor;
    logic [FLIP_W-1:0] flip_bits;
    logic [ROT_W-1:0]  rotation;
    logic              bypass_clip;
  } quad_t;

  typedef struct {
    logic [POS_W-1:0]  out_pos_x;
    logic [POS_W-1:0]  out_pos_y;
    logic [SIZE_W-1:0] out_width;
    logic [SIZE_W-1:0] out_height;
    logic [UV_W-1:0]   uv_u;
    logic [UV_W-1:0]   uv_v;
    logic [UV_W-1:0]   uv_width;
    logic [UV_W-1:0]   uv_height;
    logic [ANC_W-1:0]  out_anchor;
    logic [FLIP_W-1:0] out_flip_bits;
    logic [ROT_W-1:0]  out_rotation;
    logic              was_clipped;
  } clipped_quad_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  sqsc_quad_if quad_bus ();
  sqsc_res_if res_bus ();

  sprite_quad_scissor_clipper_core DUT (
    .clk(clk), .rst(rst), .quad_in(quad_bus), .res_out(res_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Local copy of the scissor and texture registers.
  longint scissor_left, scissor_top, scissor_w, scissor_h, tex_w, tex_h;

  clipped_quad_t expected_quads[$];
  int errors, quads_sent, words_checked, quads_culled, quads_trimmed;
  int sender_idle_pct, receiver_idle_pct, receiver_hold;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Offset of the left or top edge from the anchor point, in halves of the size.
  function automatic longint anchor_halves(logic [ANC_W-1:0] code, bit vertical);
    case (code)
      4'd1: return 0;
      4'd2: return vertical ? 0 : 1;
      4'd3: return vertical ? 0 : 2;
      4'd4: return vertical ? 1 : 2;
      4'd5: return 2;
      4'd6: return vertical ? 2 : 1;
      4'd7: return vertical ? 2 : 0;
      4'd8: return vertical ? 1 : 0;
      default: return 1;
    endcase
  endfunction

  function automatic longint texel_trim(longint trim, longint texel, longint qsize);
    if (qsize == 0) return 0;
    return (trim * texel) / qsize;
  endfunction

  function automatic logic [UV_W-1:0] normalize_uv(longint texel, longint tsize);
    longint d, v;
    d = (tsize == 0) ? 1 : tsize;
    v = clamp((texel * 256) / d, -16777216, 16777215);
    return v[UV_W-1:0];
  endfunction

  // Returns 0 when the quad is culled by the scissor.
  function automatic bit clip_quad(input quad_t q, output clipped_quad_t r);
    longint px, py, qw, qh, tx, ty, tw, th, rot;
    longint l, t, rgt, bot, cr, cb, x1, y1, x2, y2, d1x, d2x, d1y, d2y, v;
    logic [ANC_W-1:0] anc;
    bit trimmed;
    px = longint'($signed(q.pos_x));
    py = longint'($signed(q.pos_y));
    qw = longint'(q.quad_width);
    qh = longint'(q.quad_height);
    tx = longint'(q.texel_x);
    ty = longint'(q.texel_y);
    tw = longint'(q.texel_w);
    th = longint'(q.texel_h);
    rot = longint'($signed(q.rotation));
    anc = q.anchor;
    trimmed = 1'b0;
    if (!q.bypass_clip && scissor_w != 0 && scissor_h != 0) begin
      l = px - (anchor_halves(anc, 1'b0) * qw) / 2;
      t = py - (anchor_halves(anc, 1'b1) * qh) / 2;
      rgt = l + qw;
      bot = t + qh;
      cr = scissor_left + scissor_w;
      cb = scissor_top + scissor_h;
      if (l > cr || rgt < scissor_left || t > cb || bot < scissor_top) return 1'b0;
      x1 = l > scissor_left ? l : scissor_left;
      y1 = t > scissor_top ? t : scissor_top;
      x2 = rgt < cr ? rgt : cr;
      y2 = bot < cb ? bot : cb;
      d1x = texel_trim(x1 - l, tw, qw);
      d2x = texel_trim(rgt - x2, tw, qw);
      d1y = texel_trim(y1 - t, th, qh);
      d2y = texel_trim(bot - y2, th, qh);
      tx += d1x;
      tw -= d1x + d2x;
      ty += d1y;
      th -= d1y + d2y;
      px = x1;
      py = y1;
      qw = x2 - x1;
      qh = y2 - y1;
      anc = ANCHOR_CODE_TL;
      rot = 0;
      trimmed = 1'b1;
    end
    v = clamp(px, -8388608, 8388607);
    r.out_pos_x = v[POS_W-1:0];
    v = clamp(py, -8388608, 8388607);
    r.out_pos_y = v[POS_W-1:0];
    v = clamp(qw, 0, 4194303);
    r.out_width = v[SIZE_W-1:0];
    v = clamp(qh, 0, 4194303);
    r.out_height = v[SIZE_W-1:0];
    r.uv_u = normalize_uv(tx, tex_w);
    r.uv_v = normalize_uv(ty, tex_h);
    r.uv_width = normalize_uv(tw, tex_w);
    r.uv_height = normalize_uv(th, tex_h);
    r.out_anchor = anc;
    r.out_flip_bits = q.flip_bits;
    r.out_rotation = rot[ROT_W-1:0];
    r.was_clipped = trimmed;
    return 1'b1;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = ADDR_W'({idx, 2'b00});
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_CLIP_LEFT:   scissor_left = longint'($signed(value[POS_W-1:0]));
      REG_CLIP_TOP:    scissor_top = longint'($signed(value[POS_W-1:0]));
      REG_CLIP_WIDTH:  scissor_w = longint'(value[SIZE_W-1:0]);
      REG_CLIP_HEIGHT: scissor_h = longint'(value[SIZE_W-1:0]);
      REG_TEX_WIDTH:   tex_w = longint'(value[TEX_W-1:0]);
      REG_TEX_HEIGHT:  tex_h = longint'(value[TEX_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_scissor(longint left, longint top, longint w, longint h,
                             longint tw, longint th);
    write_reg(REG_CLIP_LEFT, DATA_W'(left));
    write_reg(REG_CLIP_TOP, DATA_W'(top));
    write_reg(REG_CLIP_WIDTH, DATA_W'(w));
    write_reg(REG_CLIP_HEIGHT, DATA_W'(h));
    write_reg(REG_TEX_WIDTH, DATA_W'(tw));
    write_reg(REG_TEX_HEIGHT, DATA_W'(th));
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_quad(quad_t q);
    clipped_quad_t r;
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      quad_bus.valid = 1'b0;
      @(negedge clk);
    end
    quad_bus.pos_x = q.pos_x;
    quad_bus.pos_y = q.pos_y;
    quad_bus.quad_width = q.quad_width;
    quad_bus.quad_height = q.quad_height;
    quad_bus.texel_x = q.texel_x;
    quad_bus.texel_y = q.texel_y;
    quad_bus.texel_w = q.texel_w;
    quad_bus.texel_h = q.texel_h;
    quad_bus.anchor = q.anchor;
    quad_bus.flip_bits = q.flip_bits;
    quad_bus.rotation = q.rotation;
    quad_bus.bypass_clip = q.bypass_clip;
    quad_bus.valid = 1'b1;
    @(posedge clk);
    while (!quad_bus.ready) @(posedge clk);
    quads_sent++;
    if (clip_quad(q, r)) begin
      expected_quads.push_back(r);
      if (r.was_clipped) quads_trimmed++;
    end else begin
      quads_culled++;
    end
    @(negedge clk);
  endtask

  // Lowers valid and waits for every pending word plus the pipeline latency.
  task automatic drain;
    quad_bus.valid = 1'b0;
    while (expected_quads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic quad_t make_quad(longint x, longint y, longint w, longint h,
                                      logic [ANC_W-1:0] anc, bit bypass);
    quad_t q;
    q.pos_x = x[POS_W-1:0];
    q.pos_y = y[POS_W-1:0];
    q.quad_width = w[SIZE_W-1:0];
    q.quad_height = h[SIZE_W-1:0];
    q.texel_x = SIZE_W'($urandom_range(32'h3FFFFF, 0));
    q.texel_y = SIZE_W'($urandom_range(32'h3FFFFF, 0));
    q.texel_w = SIZE_W'($urandom_range(32'h3FFFFF, 0));
    q.texel_h = SIZE_W'($urandom_range(32'h3FFFFF, 0));
    q.anchor = anc;
    q.flip_bits = FLIP_W'($urandom);
    q.rotation = ROT_W'($urandom);
    q.bypass_clip = bypass;
    return q;
  endfunction

  // Mostly quads placed around the scissor so that overlap, trim and cull all occur.
  function automatic quad_t random_quad();
    longint w, h, x, y;
    int pick;
    quad_t q;
    pick = $urandom_range(99, 0);
    w = ($urandom_range(15, 0) == 0) ? longint'($urandom_range(32'h3FFFFF, 0))
                                     : longint'($urandom_range(32'h6000, 0));
    h = ($urandom_range(15, 0) == 0) ? longint'($urandom_range(32'h3FFFFF, 0))
                                     : longint'($urandom_range(32'h6000, 0));
    if (pick < 15) begin
      q = make_quad(longint'($urandom), longint'($urandom), longint'($urandom),
                    longint'($urandom), ANC_W'($urandom), $urandom_range(1, 0));
    end else if (pick < 25) begin
      // Edge exactly on a scissor edge: kept with zero extent.
      x = ($urandom_range(1, 0)) ? scissor_left + scissor_w : scissor_left - w;
      y = ($urandom_range(1, 0)) ? scissor_top + scissor_h : scissor_top - h;
      q = make_quad(x, y, w, h, ANCHOR_CODE_TL, 1'b0);
    end else begin
      x = scissor_left - w - 512 + longint'($urandom_range(32'h7FFFFF, 0))
          % (scissor_w + 2 * w + 1025);
      y = scissor_top - h - 512 + longint'($urandom_range(32'h7FFFFF, 0))
          % (scissor_h + 2 * h + 1025);
      q = make_quad(x, y, w, h, ANC_W'($urandom), $urandom_range(9, 0) == 0);
      if ($urandom_range(3, 0) == 0) begin
        q.texel_w = SIZE_W'($urandom_range(32'h4000, 0));
        q.texel_h = SIZE_W'($urandom_range(32'h4000, 0));
      end
    end
    return q;
  endfunction

  task automatic test_reset_passthrough;
    quad_t q;
    q = make_quad(8388607, -8388608, 4194303, 0, 4'd0, 1'b0);
    q.texel_x = '1; q.texel_y = '0; q.texel_w = '1; q.texel_h = '0;
    q.rotation = 16'h7FFF; q.flip_bits = 2'b11;
    send_quad(q);
    q = make_quad(-8388608, 8388607, 0, 4194303, 4'd15, 1'b1);
    q.texel_x = '0; q.texel_y = '1; q.texel_w = '0; q.texel_h = '1;
    q.rotation = 16'h8000; q.flip_bits = 2'b00;
    send_quad(q);
    drain();
  endtask

  task automatic test_anchors_and_edges;
    quad_t q;
    set_scissor(32'h1000, 32'h800, 32'h4000, 32'h3000, 64, 32);
    for (int a = 0; a < 16; a++) begin
      q = make_quad(32'h1800, 32'h1000, 32'h1400, 32'h0E01, ANC_W'(a), 1'b0);
      send_quad(q);
    end
    // Touching right edge and touching top edge give zero extent.
    send_quad(make_quad(32'h5000, 32'h900, 32'h300, 32'h300, ANCHOR_CODE_TL, 1'b0));
    send_quad(make_quad(32'h1200, 32'h500, 32'h300, 32'h300, ANCHOR_CODE_TL, 1'b0));
    // Wholly outside, culled.
    send_quad(make_quad(32'h5001, 32'h900, 32'h300, 32'h300, ANCHOR_CODE_TL, 1'b0));
    send_quad(make_quad(-300, 32'h900, 32'h300, 32'h300, ANCHOR_CODE_TL, 1'b0));
    // Zero quad size inside the scissor: no trim.
    send_quad(make_quad(32'h2000, 32'h1000, 0, 0, 4'd0, 1'b0));
    // Bypass with clipping enabled.
    send_quad(make_quad(-8388608, 8388607, 32'h8000, 32'h8000, 4'd5, 1'b1));
    drain();
  endtask

  task automatic test_random(int count, int sidle, int ridle);
    sender_idle_pct = sidle;
    receiver_idle_pct = ridle;
    for (int i = 0; i < count; i++) send_quad(random_quad());
    drain();
  endtask

  task automatic test_backpressure;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    @(negedge clk);
    receiver_hold = 400;
    for (int i = 0; i < 120; i++) send_quad(random_quad());
    drain();
  endtask

  // Receiver: random stalls plus a long hold that it counts down itself.
  always @(negedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else if (receiver_hold > 0) begin
      res_bus.ready <= 1'b0;
      receiver_hold <= receiver_hold - 1;
    end else begin
      res_bus.ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    clipped_quad_t e;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (expected_quads.size() == 0) begin
        $error("result word with no quad expected");
        errors++;
      end else begin
        e = expected_quads.pop_front();
        words_checked++;
        check_field("out_pos_x", e.out_pos_x, res_bus.out_pos_x);
        check_field("out_pos_y", e.out_pos_y, res_bus.out_pos_y);
        check_field("out_width", e.out_width, res_bus.out_width);
        check_field("out_height", e.out_height, res_bus.out_height);
        check_field("uv_u", e.uv_u, res_bus.uv_u);
        check_field("uv_v", e.uv_v, res_bus.uv_v);
        check_field("uv_width", e.uv_width, res_bus.uv_width);
        check_field("uv_height", e.uv_height, res_bus.uv_height);
        check_field("out_anchor", e.out_anchor, res_bus.out_anchor);
        check_field("out_flip_bits", e.out_flip_bits, res_bus.out_flip_bits);
        check_field("out_rotation", e.out_rotation, res_bus.out_rotation);
        check_field("was_clipped", e.was_clipped, res_bus.was_clipped);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (quad_bus.valid && quad_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sprite_quad_scissor_clipper_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    quad_bus.valid = 1'b0;
    quad_bus.pos_x = '0; quad_bus.pos_y = '0;
    quad_bus.quad_width = '0; quad_bus.quad_height = '0;
    quad_bus.texel_x = '0; quad_bus.texel_y = '0;
    quad_bus.texel_w = '0; quad_bus.texel_h = '0;
    quad_bus.anchor = '0; quad_bus.flip_bits = '0;
    quad_bus.rotation = '0; quad_bus.bypass_clip = 1'b0;
    scissor_left = 0; scissor_top = 0; scissor_w = 0; scissor_h = 0;
    tex_w = 1; tex_h = 1;
    errors = 0; quads_sent = 0; words_checked = 0; quads_culled = 0; quads_trimmed = 0;
    sender_idle_pct = 0; receiver_idle_pct = 0; receiver_hold = 0; quiet_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_passthrough();
    test_anchors_and_edges();
    set_scissor(-8388608, -8388608, 32'h3FFFFF, 32'h3FFFFF, 16384, 16384);
    test_random(160, 31, 85);
    set_scissor(32'h3000, -32'h2000, 32'h8000, 32'h6000, 0, 32767);
    test_random(160, 31, 85);
    set_scissor(32'h7FF000, 32'h7FF000, 32'h100, 32'h1, 3, 1);
    test_random(160, 85, 31);
    set_scissor(-32'h1000, 32'h400, 32'h20000, 32'h18000, 255, 7);
    test_random(150, 85, 31);
    test_backpressure();
    set_scissor(0, 0, 32'h4000, 32'h4000, 128, 0);
    test_random(160, 0, 0);
    set_scissor(32'h2000, 32'h2000, 0, 32'h4000, 16, 16);
    test_random(40, 0, 0);

    $display("Sent %0d quads over eight register settings; %0d words checked,",
             quads_sent, words_checked);
    $display("%0d quads trimmed by the scissor and %0d culled.", quads_trimmed, quads_culled);
    if (errors == 0 && expected_quads.size() == 0) begin
      $display("sprite_quad_scissor_clipper_core verification clean");
    end else begin
      $display("sprite_quad_scissor_clipper_core verification failed");
    end
    $finish;
  end

endmodule
